FILE: sv/aam_pkg.sv
// ----------------------------------------------------------------------------
// aam_pkg
// shared types and constants of the averaging and axis range map block
// ----------------------------------------------------------------------------
package aam_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int CHANNEL_W  = 2;
  localparam int VALUE_W    = 16;
  localparam int CAL_W      = 12;
  localparam int NUM_CAL    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // map arithmetic widths
  localparam int DIFF_W    = CAL_W + 1;
  localparam int SPAN_W    = VALUE_W + 1;
  localparam int PROD_W    = DIFF_W + SPAN_W;
  localparam int MAG_W     = 28;
  localparam int QUO_W     = MAG_W + 1;
  localparam int SUM2_W    = QUO_W + 1;
  localparam int DIV_STEPS = MAG_W;
  localparam int DIV_CNT_W = 5;

  localparam logic [CAL_W-1:0] CAL_LO_RST [NUM_CAL] = '{12'd3400, 12'd3450, 12'd1090};
  localparam logic [CAL_W-1:0] CAL_HI_RST [NUM_CAL] = '{12'd600, 12'd650, 12'd3650};
  localparam logic signed [VALUE_W-1:0] OUT_LOW_RST  = -16'sd1000;
  localparam logic signed [VALUE_W-1:0] OUT_HIGH_RST = 16'sd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CH0_IN_LOW  = 3'd0,
    CFG_CH0_IN_HIGH = 3'd1,
    CFG_CH1_IN_LOW  = 3'd2,
    CFG_CH1_IN_HIGH = 3'd3,
    CFG_CH2_IN_LOW  = 3'd4,
    CFG_CH2_IN_HIGH = 3'd5,
    CFG_OUT_LOW     = 3'd6,
    CFG_OUT_HIGH    = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_STATE,
    ST_RD_WIN,
    ST_AVG_MUL,
    ST_AVG_FIX,
    ST_MAP_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: sv/aam_if.sv
// ----------------------------------------------------------------------------
// aam_if
// valid/ready channels carrying sample items and axis result items
// ----------------------------------------------------------------------------
interface aam_in_if import aam_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] channel;
  logic [SAMPLE_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface aam_out_if import aam_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CHANNEL_W-1:0]       axis_channel;
  logic [SAMPLE_W-1:0]        average;
  logic signed [VALUE_W-1:0]  axis_value;

  modport source (output valid, output axis_channel, output average, output axis_value,
                  input ready);
  modport sink   (input valid, input axis_channel, input average, input axis_value,
                  output ready);
endinterface

FILE: sv/aam_ram.sv
// ----------------------------------------------------------------------------
// aam_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module aam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/axis_average_and_range_map.sv
// ----------------------------------------------------------------------------
// axis_average_and_range_map
// per channel moving average of converter samples, mapped linearly from the
// channel calibration range to the output range and clamped
// ----------------------------------------------------------------------------
//  port      dir   handshake          carries
//  in_item   sink  valid/ready        channel, sample
//  out_item  src   valid/ready        axis_channel, average, axis_value
//  cfg_*     in    cfg_we, no ready   cfg_index, cfg_data
//
//  one item at a time; the range map runs a bit-serial divider of 28 steps,
//  which a flat calibration skips
//  a sample of an unused channel is taken and dropped with no result;
//  ring samples live in one ram, sum and slot pointer per channel in another;
//  valid bits cleared by reset make both read as zero, no clearing pass
//  a finished result waits in the output register; the next item is taken
//  meanwhile and stalls only at its own result if that register is still full
// ----------------------------------------------------------------------------
module axis_average_and_range_map import aam_pkg::*; #(
  parameter int WINDOW   = 10,
  parameter int CHANNELS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  aam_in_if.sink                in_item,
  aam_out_if.source             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = SAMPLE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WIN_DEPTH  = CHANNELS * WINDOW;
  localparam int WAW        = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int STW        = SUM_W + PTR_W;
  localparam int RCP_K      = SUM_W;
  localparam int RCP_W      = RCP_K + 1;
  localparam int AVG_PROD_W = SUM_W + RCP_W;
  localparam int WIN_W      = $clog2(WINDOW + 1);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RCP_K) / WINDOW);
  localparam logic [WIN_W-1:0] WIN_C = WIN_W'(WINDOW);

  state_t st_r, st_nxt;

  // configuration registers
  logic [CAL_W-1:0]          cal_lo_r [NUM_CAL];
  logic [CAL_W-1:0]          cal_hi_r [NUM_CAL];
  logic signed [VALUE_W-1:0] out_low_r, out_high_r;

  // datapath registers
  logic [CHANNEL_W-1:0]      ch_r;
  logic [SAMPLE_W-1:0]       smp_r;
  logic [PTR_W-1:0]          ptr_r;
  logic [SUM_W-1:0]          sum_r;
  logic [WAW-1:0]            win_addr_r;
  logic [AVG_PROD_W-1:0]     avg_prod_r;
  logic [SAMPLE_W-1:0]       avg_r;
  logic signed [PROD_W-1:0]  map_r;
  logic signed [DIFF_W-1:0]  den_r;
  logic [MAG_W-1:0]          quo_r;
  logic [CAL_W-1:0]          rem_r;
  logic [CAL_W-1:0]          dvs_r;
  logic                      neg_r;
  logic                      flat_r;
  logic [DIV_CNT_W-1:0]      cnt_r;

  logic                      win_vld_r [WIN_DEPTH];
  logic                      st_vld_r  [CHANNELS];

  logic [CHANNEL_W-1:0]      out_ch_r;
  logic [SAMPLE_W-1:0]       out_avg_r;
  logic signed [VALUE_W-1:0] out_val_r;
  logic                      out_valid_r;

  // control
  logic in_ready, st_we, win_we, out_load, out_free, in_range;

  // ram ports
  logic [CH_W-1:0]     ch_idx;
  logic [CH_W-1:0]     st_raddr;
  logic [STW-1:0]      st_rdata, st_wdata;
  logic [SAMPLE_W-1:0] win_rdata;

  // comb datapath
  logic [STW-1:0]            st_word;
  logic [SUM_W-1:0]          sum_old;
  logic [PTR_W-1:0]          ptr_cur, ptr_next;
  logic [WAW-1:0]            win_addr_nxt;
  logic [SAMPLE_W-1:0]       old_smp;
  logic [SUM_W-1:0]          sum_nxt;
  logic [SUM_W-1:0]          q_est;
  logic [SUM_W-1:0]          q_times_w;
  logic [SUM_W-1:0]          avg_rem;
  logic [SUM_W-1:0]          avg_full;
  logic [CAL_W-1:0]          cal_lo, cal_hi;
  logic signed [DIFF_W-1:0]  diff, den;
  logic signed [SPAN_W-1:0]  span;
  logic signed [PROD_W-1:0]  map_prod;
  logic [PROD_W-1:0]         map_mag;
  logic [DIFF_W-1:0]         den_mag;
  logic [DIFF_W-1:0]         trial, trial_sub;
  logic                      trial_ge;
  logic signed [QUO_W-1:0]   quo_s;
  logic signed [SUM2_W-1:0]  mapped, olo_x, ohi_x;
  logic signed [VALUE_W-1:0] val_nxt;

  assign ch_idx   = CH_W'(ch_r);
  assign st_raddr = CH_W'(in_item.channel);
  assign in_range = int'(in_item.channel) < CHANNELS;
  assign out_free = !out_valid_r || out_item.ready;

  aam_ram #(
    .WIDTH (STW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (ch_idx),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  aam_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WIN_DEPTH)
  ) u_window_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_addr_r),
    .wdata (smp_r),
    .raddr (win_addr_nxt),
    .rdata (win_rdata)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (in_item.valid && in_range) st_nxt = ST_RD_STATE;
      ST_RD_STATE: st_nxt = ST_RD_WIN;
      ST_RD_WIN:   st_nxt = ST_AVG_MUL;
      ST_AVG_MUL:  st_nxt = ST_AVG_FIX;
      ST_AVG_FIX:  st_nxt = ST_MAP_MUL;
      ST_MAP_MUL:  st_nxt = ST_DIV_INIT;
      ST_DIV_INIT: st_nxt = (den_r == '0) ? ST_DONE : ST_DIV;
      ST_DIV:      if (cnt_r == '0) st_nxt = ST_DONE;
      ST_DONE:     if (out_free) st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    st_we    = 1'b0;
    win_we   = 1'b0;
    out_load = 1'b0;
    case (st_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_RD_WIN: begin
        st_we  = 1'b1;
        win_we = 1'b1;
      end
      ST_DONE:   out_load = out_free;
      default:   ;
    endcase
  end

  assign in_item.ready = in_ready;

  // ring and sum update
  always_comb begin
    st_word      = st_vld_r[ch_idx] ? st_rdata : '0;
    sum_old      = st_word[STW-1:PTR_W];
    ptr_cur      = (int'(st_word[PTR_W-1:0]) >= WINDOW) ? '0 : st_word[PTR_W-1:0];
    win_addr_nxt = WAW'(int'(ch_idx) * WINDOW + int'(ptr_cur));
    ptr_next     = (int'(ptr_r) + 1 >= WINDOW) ? '0 : PTR_W'(int'(ptr_r) + 1);
    old_smp      = win_vld_r[win_addr_r] ? win_rdata : '0;
    sum_nxt      = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
    st_wdata     = {sum_nxt, ptr_next};
  end

  // average by reciprocal with one correction step
  always_comb begin
    q_est     = avg_prod_r[RCP_K +: SUM_W];
    q_times_w = SUM_W'(q_est * WIN_C);
    avg_rem   = sum_r - q_times_w;
    avg_full  = (int'(avg_rem) >= WINDOW) ? q_est + 1'b1 : q_est;
  end

  // range map operands
  always_comb begin
    cal_lo = '0;
    cal_hi = '0;
    if (int'(ch_r) < NUM_CAL) begin
      cal_lo = cal_lo_r[ch_r];
      cal_hi = cal_hi_r[ch_r];
    end
    diff     = $signed({1'b0, avg_r}) - $signed({1'b0, cal_lo});
    den      = $signed({1'b0, cal_hi}) - $signed({1'b0, cal_lo});
    span     = $signed({out_high_r[VALUE_W-1], out_high_r})
             - $signed({out_low_r[VALUE_W-1], out_low_r});
    map_prod = PROD_W'(diff) * PROD_W'(span);
    map_mag  = map_r[PROD_W-1] ? PROD_W'(-map_r) : PROD_W'(map_r);
    den_mag  = den_r[DIFF_W-1] ? DIFF_W'(-den_r) : DIFF_W'(den_r);
  end

  // divider step
  always_comb begin
    trial     = {rem_r, quo_r[MAG_W-1]};
    trial_ge  = trial >= {1'b0, dvs_r};
    trial_sub = trial - {1'b0, dvs_r};
  end

  // sign, offset and clamp
  always_comb begin
    quo_s  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    olo_x  = SUM2_W'(out_low_r);
    ohi_x  = SUM2_W'(out_high_r);
    mapped = SUM2_W'(quo_s) + olo_x;
    if (flat_r) begin
      val_nxt = out_low_r;
    end else if (mapped > ohi_x) begin
      val_nxt = out_high_r;
    end else if (mapped < olo_x) begin
      val_nxt = out_low_r;
    end else begin
      val_nxt = VALUE_W'(mapped);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_lo_r   <= CAL_LO_RST;
      cal_hi_r   <= CAL_HI_RST;
      out_low_r  <= OUT_LOW_RST;
      out_high_r <= OUT_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CH0_IN_LOW:  cal_lo_r[0] <= cfg_data[CAL_W-1:0];
        CFG_CH0_IN_HIGH: cal_hi_r[0] <= cfg_data[CAL_W-1:0];
        CFG_CH1_IN_LOW:  cal_lo_r[1] <= cfg_data[CAL_W-1:0];
        CFG_CH1_IN_HIGH: cal_hi_r[1] <= cfg_data[CAL_W-1:0];
        CFG_CH2_IN_LOW:  cal_lo_r[2] <= cfg_data[CAL_W-1:0];
        CFG_CH2_IN_HIGH: cal_hi_r[2] <= cfg_data[CAL_W-1:0];
        CFG_OUT_LOW:     out_low_r   <= $signed(cfg_data[VALUE_W-1:0]);
        CFG_OUT_HIGH:    out_high_r  <= $signed(cfg_data[VALUE_W-1:0]);
        default:         ;
      endcase
    end
  end

  // valid bits of both rams
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) win_vld_r[i] <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) st_vld_r[i] <= 1'b0;
    end else begin
      if (win_we) win_vld_r[win_addr_r] <= 1'b1;
      if (st_we) st_vld_r[ch_idx] <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        ch_r  <= in_item.channel;
        smp_r <= in_item.sample;
      end
      ST_RD_STATE: begin
        sum_r      <= sum_old;
        ptr_r      <= ptr_cur;
        win_addr_r <= win_addr_nxt;
      end
      ST_RD_WIN:   sum_r <= sum_nxt;
      ST_AVG_MUL:  avg_prod_r <= AVG_PROD_W'(sum_r) * AVG_PROD_W'(RECIP);
      ST_AVG_FIX:  avg_r <= avg_full[SAMPLE_W-1:0];
      ST_MAP_MUL: begin
        map_r <= map_prod;
        den_r <= den;
      end
      ST_DIV_INIT: begin
        neg_r  <= map_r[PROD_W-1] ^ den_r[DIFF_W-1];
        quo_r  <= map_mag[MAG_W-1:0];
        dvs_r  <= den_mag[CAL_W-1:0];
        rem_r  <= '0;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
        flat_r <= (den_r == '0);
      end
      ST_DIV: begin
        rem_r <= trial_ge ? trial_sub[CAL_W-1:0] : trial[CAL_W-1:0];
        quo_r <= {quo_r[MAG_W-2:0], trial_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r  <= ch_r;
      out_avg_r <= avg_r;
      out_val_r <= val_nxt;
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.axis_channel = out_ch_r;
  assign out_item.average      = out_avg_r;
  assign out_item.axis_value   = out_val_r;

  // corrected average is the exact truncated quotient
  a_avg_exact: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MAP_MUL |->
      (int'(avg_r) * WINDOW <= int'(sum_r)) && (int'(sum_r) < (int'(avg_r) + 1) * WINDOW))
    else $error("average correction off by more than one");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> (rem_r < dvs_r) && (dvs_r != '0))
    else $error("divider remainder out of range");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && !out_item.ready))
    else $error("result register overwritten");

  // no item taken while one is in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.ready |-> st_r == ST_IDLE && !st_we && !win_we)
    else $error("item accepted while busy");

  // clamped value lies in an ordered output range
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (out_low_r <= out_high_r) |=>
      (out_val_r >= $past(out_low_r)) && (out_val_r <= $past(out_high_r)))
    else $error("axis value outside output range");

endmodule

FILE: tb/tb_axis_average_and_range_map.sv
// ----------------------------------------------------------------------------
// tb_axis_average_and_range_map
// self-checking bench for the per channel moving average and axis range map:
// a local predictor keeps its own sample rings, sums and map settings, every
// accepted item of a used channel queues the expected result and a monitor
// compares each delivered result field by field; directed corners first, then
// random sample streams, several map settings, sender/receiver idling mixes
// ----------------------------------------------------------------------------
module tb_axis_average_and_range_map;
  import aam_pkg::*;

  localparam int WINDOW       = 10;
  localparam int CHANNELS     = 3;
  localparam int QUIET_CYCLES = 60;
  localparam int SEGMENT_LEN  = 125;

  typedef struct packed {
    logic [CHANNEL_W-1:0]      axis_channel;
    logic [SAMPLE_W-1:0]       average;
    logic signed [VALUE_W-1:0] axis_value;
  } axis_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aam_in_if  in_ch ();
  aam_out_if out_ch ();

  axis_average_and_range_map #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  int                        ring_data [CHANNELS][WINDOW];
  int                        ring_sum  [CHANNELS];
  int                        ring_slot [CHANNELS];
  logic [CAL_W-1:0]          cal_low   [NUM_CAL];
  logic [CAL_W-1:0]          cal_high  [NUM_CAL];
  logic signed [VALUE_W-1:0] range_low;
  logic signed [VALUE_W-1:0] range_high;

  axis_result_t axis_due_q [$];

  int send_idle_pct;
  int stall_pct;
  int error_count;
  int samples_sent;
  int dropped_samples;
  int results_seen;
  int map_settings;

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    axis_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (axis_due_q.size() == 0) begin
        $error("result item with no pending sample: channel %0d average %0d value %0d",
               out_ch.axis_channel, out_ch.average, out_ch.axis_value);
        error_count++;
      end else begin
        want = axis_due_q.pop_front();
        if (out_ch.axis_channel !== want.axis_channel) begin
          $error("axis_channel: expected %0d, got %0d", want.axis_channel,
                 out_ch.axis_channel);
          error_count++;
        end
        if (out_ch.average !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, out_ch.average);
          error_count++;
        end
        if (out_ch.axis_value !== want.axis_value) begin
          $error("axis_value: expected %0d, got %0d", want.axis_value, out_ch.axis_value);
          error_count++;
        end
      end
    end
  end

  function automatic void reset_predictor();
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < WINDOW; k++) ring_data[c][k] = 0;
      ring_sum[c]  = 0;
      ring_slot[c] = 0;
    end
    for (int c = 0; c < NUM_CAL; c++) begin
      cal_low[c]  = CAL_LO_RST[c];
      cal_high[c] = CAL_HI_RST[c];
    end
    range_low  = OUT_LOW_RST;
    range_high = OUT_HIGH_RST;
  endfunction

  function automatic void predict_axis(input logic [CHANNEL_W-1:0] ch,
                                       input logic [SAMPLE_W-1:0] s);
    int           slot;
    longint       avg_full;
    longint       lo;
    longint       hi;
    longint       olo;
    longint       ohi;
    longint       v;
    axis_result_t r;
    if (ch >= CHANNELS) begin
      dropped_samples++;
      return;
    end
    slot = ring_slot[ch];
    ring_sum[ch] = ring_sum[ch] - ring_data[ch][slot] + int'(s);
    ring_data[ch][slot] = int'(s);
    ring_slot[ch] = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    avg_full = longint'(ring_sum[ch] / WINDOW);
    lo  = longint'(cal_low[ch]);
    hi  = longint'(cal_high[ch]);
    olo = longint'(range_low);
    ohi = longint'(range_high);
    if (hi == lo) begin
      v = olo;
    end else begin
      v = ((avg_full - lo) * (ohi - olo)) / (hi - lo) + olo;
      if (v > ohi) v = ohi;
      else if (v < olo) v = olo;
    end
    r.axis_channel = ch;
    r.average      = avg_full[SAMPLE_W-1:0];
    r.axis_value   = v[VALUE_W-1:0];
    axis_due_q.push_back(r);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.channel <= ch;
    in_ch.sample  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_axis(ch, s);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (axis_due_q.size() != 0) @(negedge clk);
    // a dropped item may still be in flight
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // pushes the predictor's map settings into every register
  task automatic program_map();
    cfg_reg_t reg_id;
    reg_id = reg_id.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_id;
      case (reg_id)
        CFG_CH0_IN_LOW:  cfg_data <= {4'($urandom_range(0, 15)), cal_low[0]};
        CFG_CH0_IN_HIGH: cfg_data <= {4'($urandom_range(0, 15)), cal_high[0]};
        CFG_CH1_IN_LOW:  cfg_data <= {4'($urandom_range(0, 15)), cal_low[1]};
        CFG_CH1_IN_HIGH: cfg_data <= {4'($urandom_range(0, 15)), cal_high[1]};
        CFG_CH2_IN_LOW:  cfg_data <= {4'($urandom_range(0, 15)), cal_low[2]};
        CFG_CH2_IN_HIGH: cfg_data <= {4'($urandom_range(0, 15)), cal_high[2]};
        CFG_OUT_LOW:     cfg_data <= range_low;
        default:         cfg_data <= range_high;
      endcase
      @(negedge clk);
      reg_id = reg_id.next();
    end while (reg_id != reg_id.first());
    cfg_we <= 1'b0;
    map_settings++;
  endtask

  task automatic pick_random_map();
    logic [CAL_W-1:0] flat;
    for (int c = 0; c < NUM_CAL; c++) begin
      case ($urandom_range(0, 5))
        0: begin
          cal_low[c]  = '0;
          cal_high[c] = '1;
        end
        1: begin
          cal_low[c]  = '1;
          cal_high[c] = '0;
        end
        2: begin
          flat        = CAL_W'($urandom_range(0, 4095));
          cal_low[c]  = flat;
          cal_high[c] = flat;
        end
        default: begin
          cal_low[c]  = CAL_W'($urandom_range(0, 4095));
          cal_high[c] = CAL_W'($urandom_range(0, 4095));
        end
      endcase
    end
    case ($urandom_range(0, 5))
      0: begin
        range_low  = 16'sh8000;
        range_high = 16'sh7fff;
      end
      1: begin
        range_low  = 16'sh7fff;
        range_high = 16'sh8000;
      end
      2: begin
        range_low  = 16'($urandom_range(0, 4000) - 2000);
        range_high = 16'($urandom_range(0, 4000) - 2000);
      end
      3: begin
        range_low  = 16'($urandom_range(0, 65535));
        range_high = range_low;
      end
      default: begin
        range_low  = 16'($urandom_range(0, 65535));
        range_high = 16'($urandom_range(0, 65535));
      end
    endcase
  endtask

  task automatic test_reset_state();
    send_sample(2'd0, 12'hfff);
    send_sample(2'd0, 12'h000);
    send_sample(2'd1, 12'hfff);
    send_sample(2'd2, 12'haaa);
    send_sample(2'd2, 12'h555);
    send_sample(2'd3, 12'hfff);
    for (int k = 0; k < WINDOW; k++) send_sample(2'd0, 12'hfff);
    send_sample(2'd3, 12'h000);
  endtask

  task automatic test_map_extremes();
    drain_results();
    cal_low[0]  = '0;
    cal_high[0] = '1;
    cal_low[1]  = '1;
    cal_high[1] = '0;
    cal_low[2]  = 12'd2048;
    cal_high[2] = 12'd2048;
    range_low   = 16'sh8000;
    range_high  = 16'sh7fff;
    program_map();
    send_sample(2'd0, 12'hfff);
    send_sample(2'd1, 12'hfff);
    send_sample(2'd2, 12'hfff);
    send_sample(2'd1, 12'h000);
  endtask

  task automatic test_swapped_range();
    drain_results();
    range_low  = 16'sh7fff;
    range_high = 16'sh8000;
    program_map();
    send_sample(2'd0, 12'h800);
    send_sample(2'd1, 12'h7ff);
    send_sample(2'd2, 12'h123);
  endtask

  task automatic test_random_streams(input int idle_pct, input int stall);
    int level [CHANNELS];
    int v;
    int counted;
    logic [CHANNEL_W-1:0] ch;
    for (int c = 0; c < CHANNELS; c++) level[c] = $urandom_range(0, 4095);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int seg = 0; seg < 3; seg++) begin
      drain_results();
      pick_random_map();
      program_map();
      counted = 0;
      while (counted < SEGMENT_LEN) begin
        if ($urandom_range(0, 99) < 4) begin
          send_sample(2'd3, 12'($urandom));
        end else begin
          ch = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              v = level[ch] + int'($urandom_range(0, 64)) - 32;
              if (v < 0) v = 0;
              if (v > 4095) v = 4095;
            end
            6, 7: v = $urandom_range(0, 4095);
            8: v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
            default: begin
              level[ch] = $urandom_range(0, 4095);
              v = level[ch];
            end
          endcase
          send_sample(ch, 12'(v));
          counted++;
        end
      end
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.channel   = '0;
    in_ch.sample    = '0;
    out_ch.ready    = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    error_count     = 0;
    samples_sent    = 0;
    dropped_samples = 0;
    results_seen    = 0;
    map_settings    = 0;
    reset_predictor();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_map_extremes();
    test_swapped_range();
    test_random_streams(0, 0);
    test_random_streams(47, 0);
    test_random_streams(0, 47);
    test_random_streams(36, 36);

    send_idle_pct = 0;
    stall_pct     = 0;
    drain_results();
    if (axis_due_q.size() != 0) begin
      $error("%0d expected result items never arrived", axis_due_q.size());
      error_count++;
    end
    $display("sent %0d sample items (%0d on the unused channel), checked %0d results",
             samples_sent, dropped_samples, results_seen);
    $display("across %0d map settings and four idling mixes", map_settings);
    if (error_count == 0) begin
      $display("axis_average_and_range_map verification clean");
    end else begin
      $display("axis_average_and_range_map verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("axis_average_and_range_map verification failed");
    $finish;
  end

endmodule
